// File: design/bounded_array_list_assert.svh
// Assertion macros shared by the bounded array list RTL.
`ifndef BOUNDED_ARRAY_LIST_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define BAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bounded_array_list: assertion failed");
// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define BAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bounded_array_list: assertion failed");
`else
`define BAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/bal_pkg.sv
// Shared constants, codes and controller/datapath interface types for the array list.
`timescale 1ns / 1ps
`default_nettype none
package bal_pkg;

	localparam int LIST_DEPTH_DEF = 64;
	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int DATA_W = 64;
	localparam int ITEM_W = 7;

	// Command codes carried on the command field.
	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_SET    = 3'd2,
		CMD_GET    = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	// Source of the word written into the store.
	typedef enum logic {
		WSRC_VALUE = 1'b0,
		WSRC_RDATA = 1'b1
	} wsrc_t;

	// Write address selection.
	typedef enum logic [1:0] {
		WA_COUNT = 2'd0,
		WA_POS   = 2'd1,
		WA_IDX   = 2'd2
	} waddr_sel_t;

	// Read address selection.
	typedef enum logic {
		RA_POS    = 1'b0,
		RA_IDX_M1 = 1'b1
	} raddr_sel_t;

	// Update of the entry count.
	typedef enum logic [1:0] {
		CNT_HOLD  = 2'd0,
		CNT_INC   = 2'd1,
		CNT_CLEAR = 2'd2
	} cnt_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       ram_we;
		wsrc_t      wsrc;
		waddr_sel_t wa;
		raddr_sel_t ra;
		logic       idx_load;
		logic       idx_dec;
		cnt_op_t    cnt_op;
		logic       res_set;
		logic       res_ok;
		logic       res_rd;
		logic       out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             in_list;
		logic             has_room;
		logic             shift_last;
		logic             out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// File: design/bounded_array_list.sv
// Top level of the bounded array list: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Bounded array list of 64-bit words, up to LIST_DEPTH entries, held in one RAM with a
// registered read port. Each input word carries one command (append, insert, set, get,
// clear) and yields exactly one result word with ok, the read value and the entry count.
// Get waits for the registered RAM read before forming its result. Insert at position p
// with n entries first moves the n - p words from p upward one place up, each with a RAM
// read followed by a RAM write, and then writes the new word at p. The block works on one
// word at a time and takes the next one as soon as it returns to idle, while the previous
// result can still be waiting in the output register.
module bounded_array_list #(
	parameter int LIST_DEPTH = bal_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [bal_pkg::CMD_W-1:0]   command,
	input  wire logic [bal_pkg::POS_W-1:0]   position,
	input  wire logic [bal_pkg::DATA_W-1:0]  value_in,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             ok,
	output logic      [bal_pkg::DATA_W-1:0]  value_out,
	output logic      [bal_pkg::ITEM_W-1:0]  item_count
);

	bal_pkg::dp_cmd_t  dp_cmd;
	bal_pkg::dp_stat_t dp_stat;

	// Command sequencing.
	bal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Storage, count and result path.
	bal_datapath #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.command    (command),
		.position   (position),
		.value_in   (value_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.value_out  (value_out),
		.item_count (item_count)
	);

endmodule
`default_nettype wire

// File: design/bal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bal_ram #(
	parameter int WIDTH = bal_pkg::DATA_W,
	parameter int DEPTH = bal_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: design/bal_datapath.sv
// Datapath of the array list: input capture, entry count, shift index, store and result word.
`timescale 1ns / 1ps
`default_nettype none
module bal_datapath #(
	parameter int LIST_DEPTH = bal_pkg::LIST_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bal_pkg::dp_cmd_t            cmd,
	output bal_pkg::dp_stat_t                stat,
	input  wire logic [bal_pkg::CMD_W-1:0]   command,
	input  wire logic [bal_pkg::POS_W-1:0]   position,
	input  wire logic [bal_pkg::DATA_W-1:0]  value_in,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             ok,
	output logic      [bal_pkg::DATA_W-1:0]  value_out,
	output logic      [bal_pkg::ITEM_W-1:0]  item_count
);

	`include "bounded_array_list_assert.svh"

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int CMPW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;

	logic [bal_pkg::CMD_W-1:0]  cmd_q;
	logic [bal_pkg::POS_W-1:0]  pos_q;
	logic [bal_pkg::DATA_W-1:0] value_q;
	logic [CW-1:0]              count_q;
	logic [AW-1:0]              idx_q;
	logic                       res_ok_q;
	logic [bal_pkg::DATA_W-1:0] res_val_q;
	logic                       out_valid_q;
	logic                       ok_q;
	logic [bal_pkg::DATA_W-1:0] value_out_q;
	logic [bal_pkg::ITEM_W-1:0] item_count_q;

	logic [AW-1:0]              pos_addr;
	logic [AW-1:0]              idx_m1;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [bal_pkg::DATA_W-1:0] wdata;
	logic [bal_pkg::DATA_W-1:0] rdata;

	// Capture the command word when the controller takes it.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= command;
			pos_q   <= position;
			value_q <= value_in;
		end
	end

	// Entry count and the shift index that walks down during an insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.cnt_op)
				bal_pkg::CNT_INC:   count_q <= count_q + 1'b1;
				bal_pkg::CNT_CLEAR: count_q <= '0;
				default:            count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx_load) begin
			idx_q <= AW'(count_q);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end
	end

	// Address and data selection for the store.
	assign pos_addr = AW'(pos_q);
	assign idx_m1   = idx_q - 1'b1;

	always_comb begin
		unique case (cmd.wa)
			bal_pkg::WA_COUNT: waddr = AW'(count_q);
			bal_pkg::WA_POS:   waddr = pos_addr;
			bal_pkg::WA_IDX:   waddr = idx_q;
			default:           waddr = idx_q;
		endcase
	end

	assign raddr = (cmd.ra == bal_pkg::RA_IDX_M1) ? idx_m1 : pos_addr;
	assign wdata = (cmd.wsrc == bal_pkg::WSRC_RDATA) ? rdata : value_q;

	bal_ram #(
		.WIDTH(bal_pkg::DATA_W),
		.DEPTH(LIST_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Result word being assembled for the current command.
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_ok_q  <= cmd.res_ok;
			res_val_q <= cmd.res_rd ? rdata : '0;
		end
	end

	// Output register that holds a finished word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ok_q         <= res_ok_q;
			value_out_q  <= res_val_q;
			item_count_q <= bal_pkg::ITEM_W'(count_q);
		end
	end

	// Status toward the controller.
	assign stat.cmd        = cmd_q;
	assign stat.in_list    = CMPW'(pos_q) < CMPW'(count_q);
	assign stat.has_room   = count_q < CW'(LIST_DEPTH);
	assign stat.shift_last = (idx_m1 == pos_addr);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign value_out  = value_out_q;
	assign item_count = item_count_q;

	// The count only grows by one or drops to zero.
	`BAL_ASSERT_NOW(a_count_step, clk, arst_n, count_q != $past(count_q), (count_q == $past(count_q) + 1'b1) || (count_q == '0))
	// Every store write lands at or below the current count.
	`BAL_ASSERT_NOW(a_write_in_range, clk, arst_n, cmd.ram_we, CW'(waddr) <= count_q)

endmodule
`default_nettype wire

// File: design/bal_ctrl.sv
// Controller state machine that sequences each list command through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module bal_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bal_pkg::dp_stat_t stat,
	output bal_pkg::dp_cmd_t       cmd
);

	`include "bounded_array_list_assert.svh"

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_EXEC      = 7'b0000010,
		ST_SHIFT_RD  = 7'b0000100,
		ST_SHIFT_WR  = 7'b0001000,
		ST_INS_WR    = 7'b0010000,
		ST_READ_WAIT = 7'b0100000,
		ST_DONE      = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d     = ST_DONE;
				cmd.res_set = 1'b1;
				unique case (stat.cmd)
					bal_pkg::CMD_APPEND: begin
						if (stat.has_room) begin
							cmd.ram_we = 1'b1;
							cmd.wsrc   = bal_pkg::WSRC_VALUE;
							cmd.wa     = bal_pkg::WA_COUNT;
							cmd.cnt_op = bal_pkg::CNT_INC;
							cmd.res_ok = 1'b1;
						end
					end
					bal_pkg::CMD_INSERT: begin
						if (stat.in_list && stat.has_room) begin
							cmd.res_set  = 1'b0;
							cmd.idx_load = 1'b1;
							state_d      = ST_SHIFT_RD;
						end
					end
					bal_pkg::CMD_SET: begin
						if (stat.in_list) begin
							cmd.ram_we = 1'b1;
							cmd.wsrc   = bal_pkg::WSRC_VALUE;
							cmd.wa     = bal_pkg::WA_POS;
							cmd.res_ok = 1'b1;
						end
					end
					bal_pkg::CMD_GET: begin
						if (stat.in_list) begin
							cmd.res_set = 1'b0;
							cmd.ra      = bal_pkg::RA_POS;
							state_d     = ST_READ_WAIT;
						end
					end
					bal_pkg::CMD_CLEAR: begin
						cmd.cnt_op = bal_pkg::CNT_CLEAR;
						cmd.res_ok = 1'b1;
					end
					default: begin
						cmd.res_ok = 1'b0;
					end
				endcase
			end
			ST_SHIFT_RD: begin
				cmd.ra  = bal_pkg::RA_IDX_M1;
				state_d = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				cmd.ram_we  = 1'b1;
				cmd.wsrc    = bal_pkg::WSRC_RDATA;
				cmd.wa      = bal_pkg::WA_IDX;
				cmd.idx_dec = 1'b1;
				state_d     = stat.shift_last ? ST_INS_WR : ST_SHIFT_RD;
			end
			ST_INS_WR: begin
				cmd.ram_we  = 1'b1;
				cmd.wsrc    = bal_pkg::WSRC_VALUE;
				cmd.wa      = bal_pkg::WA_POS;
				cmd.cnt_op  = bal_pkg::CNT_INC;
				cmd.res_set = 1'b1;
				cmd.res_ok  = 1'b1;
				state_d     = ST_DONE;
			end
			ST_READ_WAIT: begin
				cmd.res_set = 1'b1;
				cmd.res_ok  = 1'b1;
				cmd.res_rd  = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// After a word is taken the block is busy with it on the next cycle.
	`BAL_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// The final insert write only happens while the list still has room.
	`BAL_ASSERT_NOW(a_insert_room, clk, arst_n, state_q == ST_INS_WR, stat.has_room)

endmodule
`default_nettype wire

// File: test/tb_bounded_array_list.sv
// Self-checking testbench for the bounded array list, with a scoreboard that shadows the list.
`timescale 1ns / 1ps
module tb_bounded_array_list;
	import bal_pkg::*;

	localparam int DEPTH = LIST_DEPTH_DEF;
	localparam int WORD_TARGET = 1200;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS = 10;
	localparam logic [CMD_W-1:0] FIRST_UNUSED = CMD_W'(CMD_CLEAR + 1);
	localparam logic [CMD_W-1:0] LAST_UNUSED = '1;

	// One result word as the list should produce it.
	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] word;
		logic [ITEM_W-1:0] count;
	} list_result_t;

	// Shadow copy of the list plus the queue of results still to come.
	class list_scoreboard;
		logic [DATA_W-1:0] words [DEPTH];
		int unsigned entries;
		int unsigned mismatches;
		list_result_t due[$];

		function new();
			entries = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted command word to the shadow list and queue its result.
		function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
				logic [DATA_W-1:0] val);
			list_result_t res;
			logic in_list;
			logic has_room;
			int unsigned i;
			res = '0;
			in_list = pos < entries;
			has_room = entries < DEPTH;
			case (cmd_t'(cmd))
			CMD_APPEND: begin
				if (has_room) begin
					words[entries] = val;
					entries++;
					res.ok = 1'b1;
				end
			end
			CMD_INSERT: begin
				if (in_list && has_room) begin
					for (i = entries; i > pos; i--)
						words[i] = words[i - 1];
					words[pos] = val;
					entries++;
					res.ok = 1'b1;
				end
			end
			CMD_SET: begin
				if (in_list) begin
					words[pos] = val;
					res.ok = 1'b1;
				end
			end
			CMD_GET: begin
				if (in_list) begin
					res.word = words[pos];
					res.ok = 1'b1;
				end
			end
			CMD_CLEAR: begin
				entries = 0;
				res.ok = 1'b1;
			end
			default: ;
			endcase
			res.count = entries[ITEM_W-1:0];
			due.push_back(res);
		endfunction

		function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		endfunction

		// Compare one accepted result word with the oldest outstanding prediction.
		function void check_result(logic ok_bit, logic [DATA_W-1:0] word,
				logic [ITEM_W-1:0] count);
			list_result_t want;
			if (due.size() == 0) begin
				report("unrequested result word", '0, word);
				return;
			end
			want = due.pop_front();
			if (ok_bit !== want.ok)
				report("ok", DATA_W'(want.ok), DATA_W'(ok_bit));
			if (word !== want.word)
				report("value_out", want.word, word);
			if (count !== want.count)
				report("item_count", DATA_W'(want.count), DATA_W'(count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [CMD_W-1:0] command = '0;
	logic [POS_W-1:0] position = '0;
	logic [DATA_W-1:0] value_in = '0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic ok;
	logic [DATA_W-1:0] value_out;
	logic [ITEM_W-1:0] item_count;

	list_scoreboard sb = new();
	int unsigned words_sent = 0;
	int unsigned idle_cycles = 0;
	bit quiet = 1'b0;

	bounded_array_list #(
		.LIST_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.position(position),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ok(ok),
		.value_out(value_out),
		.item_count(item_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Check every accepted result and watch for a stalled handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(ok, value_out, item_count);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver: short stalls mostly, a few long ones, and long runs with no stall.
	initial begin
		int unsigned run;
		int unsigned stall;
		int unsigned r;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				run = $urandom_range(50, 300);
				stall = 0;
			end else begin
				run = $urandom_range(1, 6);
				stall = (r < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly random words, with the all-zero and all-one patterns mixed in.
	function automatic logic [DATA_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [POS_W-1:0] pick_slot();
		return POS_W'($urandom_range(0, sb.entries - 1));
	endfunction

	// Present one command word and hold it until the block takes it.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		value_in <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_command(cmd, pos, val);
		words_sent++;
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
	endtask

	// Grow the list with appends and in-range inserts, touching existing entries now and then.
	task automatic grow_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (sb.entries == 0 || r < 40)
			send_word(CMD_APPEND, POS_W'($urandom), pick_word());
		else if (r < 70)
			send_word(CMD_INSERT, pick_slot(), pick_word());
		else if (r < 85)
			send_word(CMD_GET, pick_slot(), pick_word());
		else
			send_word(CMD_SET, pick_slot(), pick_word());
	endtask

	// Any command at all, weighted toward in-range access but with bad positions and noise.
	task automatic random_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25 && sb.entries > 0)
			send_word(CMD_GET, pick_slot(), pick_word());
		else if (r < 40 && sb.entries > 0)
			send_word(CMD_SET, pick_slot(), pick_word());
		else if (r < 55 && sb.entries > 0)
			send_word(CMD_INSERT, pick_slot(), pick_word());
		else if (r < 68)
			send_word(CMD_APPEND, POS_W'($urandom), pick_word());
		else if (r < 88)
			send_word(CMD_W'($urandom_range(CMD_APPEND, CMD_GET)), POS_W'($urandom),
				pick_word());
		else if (r < 96)
			send_word(CMD_W'($urandom_range(FIRST_UNUSED, LAST_UNUSED)), POS_W'($urandom),
				pick_word());
		else
			send_word(CMD_CLEAR, POS_W'($urandom), pick_word());
	endtask

	initial begin
		int unsigned episode;
		int unsigned target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every positional command is refused, insert at the count included.
		send_word(CMD_GET, 0, '0);
		send_word(CMD_SET, 0, '1);
		send_word(CMD_INSERT, 0, '1);
		send_word(CMD_APPEND, 63, '1);
		send_word(CMD_APPEND, 0, '0);
		send_word(CMD_INSERT, 2, 64'h0f0f_0f0f_0f0f_0f0f);
		send_word(CMD_INSERT, 0, 64'h0123_4567_89ab_cdef);
		send_word(CMD_INSERT, 1, 64'ha5a5_a5a5_5a5a_5a5a);
		send_word(CMD_GET, 0, '1);
		send_word(CMD_GET, 1, '0);
		send_word(CMD_GET, 2, '0);
		send_word(CMD_GET, 3, '0);
		send_word(CMD_SET, 3, 64'h5555_5555_5555_5555);
		send_word(CMD_SET, 63, 64'haaaa_aaaa_aaaa_aaaa);
		send_word(CMD_GET, 3, '0);
		send_word(CMD_GET, 63, '1);
		// Unused command codes change nothing.
		send_word(FIRST_UNUSED, 63, '1);
		send_word(CMD_W'(CMD_CLEAR + 2), 0, '1);
		send_word(LAST_UNUSED, 63, '1);
		// Clear leaves the stored words behind, but they are out of reach.
		send_word(CMD_CLEAR, 63, '1);
		send_word(CMD_GET, 0, '0);
		send_word(CMD_APPEND, 0, 64'h8000_0000_0000_0001);
		send_word(CMD_GET, 0, '0);
		drain_results();

		// Random episodes: grow the list to a target, then mix commands; some fill it up.
		episode = 0;
		while (words_sent < WORD_TARGET) begin
			quiet = ($urandom_range(0, 3) == 0);
			if (episode > 0 && $urandom_range(0, 2) == 0)
				send_word(CMD_CLEAR, POS_W'($urandom), pick_word());
			if (episode == 0 || $urandom_range(0, 3) == 0)
				target = DEPTH;
			else
				target = $urandom_range(1, 20);
			while (sb.entries < target)
				grow_step();
			repeat ($urandom_range(10, 50))
				random_step();
			if ($urandom_range(0, 4) == 0)
				drain_results();
			episode++;
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
